FILE: sv/htlp_pkg.sv
package htlp_pkg;

  localparam int DEF_CAPACITY = 256;
  localparam int HASH_W = 32;
  localparam int KEY_W = 32;
  localparam int VAL_W = 64;
  localparam int LIMIT_W = 8;
  localparam int CNT_W = 9;
  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 8'd192;

  localparam logic [1:0] CMD_GET = 2'd0;
  localparam logic [1:0] CMD_SET = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key_id;
    logic [HASH_W-1:0] key_hash;
    logic [VAL_W-1:0] value_in;
  } in_t;

  typedef struct packed {
    logic             flag;
    logic [VAL_W-1:0] value_out;
    logic             full_res;
  } out_t;

  typedef struct packed {
    logic             used;
    logic             tomb;
    logic [KEY_W-1:0] key;
  } meta_t;

  typedef struct packed {
    logic meta_en;
    logic val_en;
  } mem_wr_t;

endpackage

FILE: sv/htlp_hash_mod.sv
module htlp_hash_mod
  import htlp_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [HASH_W-1:0]           hash,
  output logic                        done,
  output logic [$clog2(CAPACITY)-1:0] rem
);

  localparam int AW = $clog2(CAPACITY);
  localparam bit IS_POW2 = (CAPACITY == (1 << AW));

  generate
    if (IS_POW2) begin : g_pow2
      logic          done_r;
      logic [AW-1:0] rem_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          rem_r <= hash[AW-1:0];
        end
      end

      assign done = done_r;
      assign rem  = rem_r;
    end else begin : g_recip
      // quotient estimate by reciprocal, low remainder bits, then one correction
      localparam int                  RW     = AW + 1;
      localparam int                  SH     = HASH_W - 1 + AW;
      localparam logic [2*HASH_W-1:0] SCALE  = (2*HASH_W)'(1) << SH;
      localparam logic [HASH_W-1:0]   RECIP  = HASH_W'(SCALE / (2*HASH_W)'(CAPACITY));
      localparam logic [RW-1:0]       CAP_LO = RW'(CAPACITY);

      logic                v1_r;
      logic                v2_r;
      logic [RW-1:0]       q_r;
      logic [RW-1:0]       hl_r;
      logic [RW-1:0]       re_r;
      logic [2*HASH_W-1:0] prod;
      logic [RW-1:0]       qc;

      assign prod = {{HASH_W{1'b0}}, hash} * {{HASH_W{1'b0}}, RECIP};
      assign qc   = q_r * CAP_LO;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v1_r <= 1'b0;
          v2_r <= 1'b0;
        end else begin
          v1_r <= start;
          v2_r <= v1_r;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          q_r  <= prod[SH +: RW];
          hl_r <= hash[RW-1:0];
        end
        if (v1_r) begin
          re_r <= hl_r - qc;
        end
      end

      assign done = v2_r;
      assign rem  = (re_r >= CAP_LO) ? AW'(re_r - CAP_LO) : re_r[AW-1:0];
    end
  endgenerate

endmodule

FILE: sv/htlp_slot_mem.sv
module htlp_slot_mem
  import htlp_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr,
  input  mem_wr_t                     wr_req,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  meta_t                       wr_meta,
  input  logic [VAL_W-1:0]            wr_val,
  output meta_t                       rd_meta,
  output logic [VAL_W-1:0]            rd_val
);

  meta_t            meta_mem [CAPACITY];
  logic [VAL_W-1:0] val_mem  [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_req.meta_en) begin
      meta_mem[wr_addr] <= wr_meta;
    end
    rd_meta <= meta_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_req.val_en) begin
      val_mem[wr_addr] <= wr_val;
    end
    rd_val <= val_mem[rd_addr];
  end

endmodule

FILE: sv/hash_table_linear_probe_core.sv
// channel  direction  handshake              payload
// in_      input      in_valid / in_ready    in_data (in_t)
// out_     output     out_valid / out_ready  out_data (out_t)
// cfg_     input      cfg_valid / cfg_ready  cfg_data (load limit)
//
// one item at a time: the item is accepted, its hash is reduced mod CAPACITY
// (through done_r for a power-of-two CAPACITY, else through v1_r and v2_r), then
// each probed slot is read in turn through the registered read port of the slot memory
// the terminal probe cycle writes back and loads the output register
// after reset a clearing pass over every slot holds in_ready low
// a full output register holds the last probe cycle until out_ready
module hash_table_linear_probe_core
  import htlp_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  localparam int AW = $clog2(CAPACITY);

  localparam logic [1:0] S_CLR   = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_HASH  = 2'd2;
  localparam logic [1:0] S_PROBE = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic               out_valid_r, out_valid_nxt;
  in_t                item_r;
  out_t               out_r, out_nxt;

  logic               accept;
  logic               mod_done;
  logic [AW-1:0]      mod_rem;
  mem_wr_t            wr_req;
  logic [AW-1:0]      wr_addr;
  meta_t              wr_meta;
  meta_t              rd_meta;
  logic [VAL_W-1:0]   rd_val;

  logic               hit, empty, last, stop, room, out_free;
  logic [AW-1:0]      idx_inc;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  htlp_hash_mod #(.CAPACITY(CAPACITY)) u_hash_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .hash  (in_data.key_hash),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  htlp_slot_mem #(.CAPACITY(CAPACITY)) u_slot_mem (
    .clk     (clk),
    .rd_addr (idx_nxt),
    .wr_req  (wr_req),
    .wr_addr (wr_addr),
    .wr_meta (wr_meta),
    .wr_val  (item_r.value_in),
    .rd_meta (rd_meta),
    .rd_val  (rd_val)
  );

  assign hit      = rd_meta.used && (rd_meta.key == item_r.key_id);
  assign empty    = !rd_meta.used && !rd_meta.tomb;
  assign last     = (pcnt_r == AW'(CAPACITY - 1));
  assign stop     = hit || empty || last;
  assign room     = (({1'b0, count_r} + (CNT_W+1)'(1)) <= (CNT_W+1)'(limit_r));
  assign out_free = !out_valid_r || out_ready;
  assign idx_inc  = (idx_r == AW'(CAPACITY - 1)) ? '0 : idx_r + AW'(1);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pcnt_nxt      = pcnt_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    wr_req        = '0;
    wr_addr       = idx_r;
    wr_meta       = '0;
    case (state_r)
      S_CLR: begin
        wr_req.meta_en = 1'b1;
        idx_nxt        = idx_inc;
        if (last) begin
          state_nxt = S_IDLE;
        end
        pcnt_nxt = pcnt_r + AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (mod_done) begin
          idx_nxt   = mod_rem;
          pcnt_nxt  = '0;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!stop) begin
          idx_nxt  = idx_inc;
          pcnt_nxt = pcnt_r + AW'(1);
        end else if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          case (item_r.cmd)
            CMD_GET: begin
              out_nxt.flag = hit;
              if (hit) begin
                out_nxt.value_out = rd_val;
              end
            end
            CMD_SET: begin
              if (hit) begin
                wr_req.val_en = 1'b1;
              end else if (empty && room) begin
                wr_req.meta_en = 1'b1;
                wr_req.val_en  = 1'b1;
                wr_meta.used   = 1'b1;
                wr_meta.key    = item_r.key_id;
                count_nxt      = count_r + CNT_W'(1);
                out_nxt.flag   = 1'b1;
              end else begin
                out_nxt.full_res = 1'b1;
              end
            end
            CMD_DEL: begin
              if (hit) begin
                wr_req.meta_en = 1'b1;
                wr_meta.tomb   = 1'b1;
                wr_meta.key    = rd_meta.key;
                out_nxt.flag   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      pcnt_r      <= '0;
      count_r     <= '0;
      limit_r     <= LOAD_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pcnt_r      <= pcnt_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    out_r <= out_nxt;
  end

endmodule

FILE: sv/htlp_checker.sv
module htlp_checker
  import htlp_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a rejected set never reports a new key
  a_full_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.full_res |-> !out_data.flag)
    else $error("full result with flag set");

  // a value is only returned by a successful get
  a_value_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.value_out != '0) |-> out_data.flag && !out_data.full_res)
    else $error("value without hit");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind hash_table_linear_probe_core htlp_checker u_htlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
